>>> hw/rtl/lcdn_pkg.sv
`timescale 1ns / 1ps

package lcdn_pkg;

    // Field widths of the command and result words.
    localparam int OP_W     = 3;
    localparam int BYTE_W   = 8;
    localparam int COL_W    = 6;
    localparam int NIB_W    = 4;
    localparam int WAIT_W   = 16;
    localparam int STROBE_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int POS_W    = 6;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_INIT  = 3'd1;
    localparam logic [OP_W-1:0] OP_CMD   = 3'd2;
    localparam logic [OP_W-1:0] OP_DATA  = 3'd3;
    localparam logic [OP_W-1:0] OP_POS   = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_STROBE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POWERUP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THIRD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR   = 3'd5;

    // Register reset values.
    localparam logic [STROBE_W-1:0] RST_STROBE  = 8'd50;
    localparam logic [WAIT_W-1:0]   RST_POWERUP = 16'd15000;
    localparam logic [WAIT_W-1:0]   RST_SECOND  = 16'd4000;
    localparam logic [WAIT_W-1:0]   RST_THIRD   = 16'd100;
    localparam logic [WAIT_W-1:0]   RST_GAP     = 16'd1000;
    localparam logic [WAIT_W-1:0]   RST_CLEAR   = 16'd1500;

    // Cursor address forming.
    localparam logic [BYTE_W-1:0] ADDR_FLAG  = 8'b1000_0000;
    localparam logic [BYTE_W-1:0] ROW_STRIDE = 8'h40;
    localparam logic [BYTE_W-1:0] LOW_MASK   = 8'b0000_1111;

    // Init and clear nibbles and bytes.
    localparam logic [NIB_W-1:0]  INIT_WAKE_NIB = 4'b0011;
    localparam logic [NIB_W-1:0]  INIT_4BIT_NIB = 4'b0010;
    localparam logic [BYTE_W-1:0] FUNC_SET_BYTE = 8'b0010_1000;
    localparam logic [BYTE_W-1:0] DISP_ON_BYTE  = 8'b0000_1100;
    localparam logic [BYTE_W-1:0] ENTRY_BYTE    = 8'b0000_0110;
    localparam logic [BYTE_W-1:0] CLEAR_BYTE    = 8'b0000_0001;

    // Sequence positions. The three programs are laid out back to back, each
    // closed by an end position that also serves as the idle state.
    localparam int POS_COUNT = 41;
    localparam logic [POS_W-1:0] POS_INIT_FIRST  = 6'd0;
    localparam logic [POS_W-1:0] POS_INIT_END    = 6'd28;
    localparam logic [POS_W-1:0] POS_USER_FIRST  = 6'd29;
    localparam logic [POS_W-1:0] POS_USER_END    = 6'd34;
    localparam logic [POS_W-1:0] POS_CLEAR_FIRST = 6'd35;
    localparam logic [POS_W-1:0] POS_CLEAR_END   = 6'd40;
    localparam logic [POS_W-1:0] POS_IDLE        = POS_INIT_END;

    // Wait source of a position.
    localparam logic [2:0] WS_END     = 3'd0;
    localparam logic [2:0] WS_STROBE  = 3'd1;
    localparam logic [2:0] WS_POWERUP = 3'd2;
    localparam logic [2:0] WS_SECOND  = 3'd3;
    localparam logic [2:0] WS_THIRD   = 3'd4;
    localparam logic [2:0] WS_GAP     = 3'd5;
    localparam logic [2:0] WS_CLEAR   = 3'd6;
    localparam logic [2:0] WS_ZERO    = 3'd7;

    typedef struct packed {
        logic [STROBE_W-1:0] strobe;
        logic [WAIT_W-1:0]   powerup;
        logic [WAIT_W-1:0]   second;
        logic [WAIT_W-1:0]   third;
        logic [WAIT_W-1:0]   gap;
        logic [WAIT_W-1:0]   clear;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] value;
        logic [COL_W-1:0]  column;
        logic              row;
    } item_t;

    typedef struct packed {
        logic             lcd_enable;
        logic             lcd_select;
        logic [NIB_W-1:0] lcd_nibble;
        logic             busy_res;
        logic             rejected;
    } result_t;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] pos;
    } prev_t;

    // Which wait is loaded on entering a position.
    function automatic logic [2:0] lcdn_wsrc(input logic [POS_W-1:0] p);
        logic [2:0] w;
        unique case (p)
            6'd0:  w = WS_POWERUP;
            6'd3:  w = WS_SECOND;
            6'd6:  w = WS_THIRD;
            6'd9, 6'd12, 6'd17, 6'd22, 6'd27: w = WS_GAP;
            6'd33: w = WS_ZERO;
            6'd39: w = WS_CLEAR;
            6'd1, 6'd2, 6'd4, 6'd5, 6'd7, 6'd8, 6'd10, 6'd11,
            6'd13, 6'd14, 6'd15, 6'd16, 6'd18, 6'd19, 6'd20, 6'd21,
            6'd23, 6'd24, 6'd25, 6'd26, 6'd29, 6'd30, 6'd31, 6'd32,
            6'd35, 6'd36, 6'd37, 6'd38: w = WS_STROBE;
            default: w = WS_END;
        endcase
        return w;
    endfunction

    // Positions where E is high; leaving one drives its nibble and lowers E.
    function automatic logic lcdn_is_e0(input logic [POS_W-1:0] p);
        logic e;
        unique case (p)
            6'd1, 6'd4, 6'd7, 6'd10, 6'd13, 6'd15, 6'd18, 6'd20, 6'd23, 6'd25,
            6'd29, 6'd31, 6'd35, 6'd37: e = 1'b1;
            default: e = 1'b0;
        endcase
        return e;
    endfunction

    // Nibble driven on leaving a strobe-high position.
    function automatic logic [NIB_W-1:0] lcdn_e0_nibble(input logic [POS_W-1:0] p,
                                                         input logic [BYTE_W-1:0] latch);
        logic [NIB_W-1:0] n;
        unique case (p)
            6'd1, 6'd4, 6'd7: n = INIT_WAKE_NIB;
            6'd10: n = INIT_4BIT_NIB;
            6'd13: n = FUNC_SET_BYTE[7:4];
            6'd15: n = FUNC_SET_BYTE[3:0];
            6'd18: n = DISP_ON_BYTE[7:4];
            6'd20: n = DISP_ON_BYTE[3:0];
            6'd23: n = ENTRY_BYTE[7:4];
            6'd25: n = ENTRY_BYTE[3:0];
            6'd29: n = latch[7:4];
            6'd31: n = NIB_W'(latch & LOW_MASK);
            6'd35: n = CLEAR_BYTE[7:4];
            6'd37: n = CLEAR_BYTE[3:0];
            default: n = '0;
        endcase
        return n;
    endfunction

    // Latest strobe-high position before p within the same program.
    function automatic prev_t lcdn_prev_e0(input logic [POS_W-1:0] p);
        prev_t r;
        r.valid = 1'b1;
        unique case (p)
            6'd2, 6'd3, 6'd4:    r.pos = 6'd1;
            6'd5, 6'd6, 6'd7:    r.pos = 6'd4;
            6'd8, 6'd9, 6'd10:   r.pos = 6'd7;
            6'd11, 6'd12, 6'd13: r.pos = 6'd10;
            6'd14, 6'd15:        r.pos = 6'd13;
            6'd16, 6'd17, 6'd18: r.pos = 6'd15;
            6'd19, 6'd20:        r.pos = 6'd18;
            6'd21, 6'd22, 6'd23: r.pos = 6'd20;
            6'd24, 6'd25:        r.pos = 6'd23;
            6'd26, 6'd27, 6'd28: r.pos = 6'd25;
            6'd30, 6'd31:        r.pos = 6'd29;
            6'd32, 6'd33, 6'd34: r.pos = 6'd31;
            6'd36, 6'd37:        r.pos = 6'd35;
            6'd38, 6'd39, 6'd40: r.pos = 6'd37;
            default:
            begin
                r.valid = 1'b0;
                r.pos   = '0;
            end
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/lcdn_ifs.sv
`timescale 1ns / 1ps

// Command word channel.
interface lcdn_cmd_if import lcdn_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] value;
    logic [COL_W-1:0]  column;
    logic              row;

    modport source (output valid, op, value, column, row, input ready);
    modport sink (input valid, op, value, column, row, output ready);
endinterface

// Result word channel.
interface lcdn_res_if import lcdn_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             lcd_enable;
    logic             lcd_select;
    logic [NIB_W-1:0] lcd_nibble;
    logic             busy_res;
    logic             rejected;

    modport source (output valid, lcd_enable, lcd_select, lcd_nibble, busy_res, rejected,
                    input ready);
    modport sink (input valid, lcd_enable, lcd_select, lcd_nibble, busy_res, rejected,
                  output ready);
endinterface

// Configuration write channel.
interface lcdn_cfg_if import lcdn_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WAIT_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/lcdn_cfg_regs.sv
`timescale 1ns / 1ps

module lcdn_cfg_regs
    import lcdn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [WAIT_W-1:0]    wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_STROBE:  cfg_next.strobe  = wr_data[STROBE_W-1:0];
                REG_POWERUP: cfg_next.powerup = wr_data;
                REG_SECOND:  cfg_next.second  = wr_data;
                REG_THIRD:   cfg_next.third   = wr_data;
                REG_GAP:     cfg_next.gap     = wr_data;
                REG_CLEAR:   cfg_next.clear   = wr_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.strobe  <= RST_STROBE;
            cfg_reg.powerup <= RST_POWERUP;
            cfg_reg.second  <= RST_SECOND;
            cfg_reg.third   <= RST_THIRD;
            cfg_reg.gap     <= RST_GAP;
            cfg_reg.clear   <= RST_CLEAR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/lcdn_seq_core.sv
`timescale 1ns / 1ps

module lcdn_seq_core
    import lcdn_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [WAIT_W-1:0] cnt_reg, cnt_next;
    logic [BYTE_W-1:0] latch_reg, latch_next;
    logic              en_reg, en_next;
    logic              sel_reg, sel_next;
    logic [NIB_W-1:0]  nib_reg, nib_next;

    logic [POS_COUNT-1:0] stop_vec;
    logic [POS_W-1:0]     start_pos;
    logic [POS_W-1:0]     from_pos;
    logic [POS_W-1:0]     stop_pos;
    logic                 run;
    logic                 busy;
    logic                 rejected;
    logic [BYTE_W-1:0]    addr_byte;
    prev_t                prev;

    function automatic logic [WAIT_W-1:0] wait_value(input logic [2:0] ws, input cfg_t c);
        logic [WAIT_W-1:0] v;
        unique case (ws)
            WS_STROBE:  v = WAIT_W'(c.strobe);
            WS_POWERUP: v = c.powerup;
            WS_SECOND:  v = c.second;
            WS_THIRD:   v = c.third;
            WS_GAP:     v = c.gap;
            WS_CLEAR:   v = c.clear;
            default:    v = '0;
        endcase
        return v;
    endfunction

    assign busy = (pos_reg != POS_INIT_END) && (pos_reg != POS_USER_END)
                  && (pos_reg != POS_CLEAR_END);

    // Cursor address: row offset plus column, with the address flag set.
    assign addr_byte = ((item.row ? ROW_STRIDE : '0) + BYTE_W'(item.column)) | ADDR_FLAG;

    // A position holds the sequence when its wait is nonzero or it ends a program.
    always_comb
    begin
        for (int i = 0; i < POS_COUNT; i++)
        begin
            stop_vec[i] = (lcdn_wsrc(POS_W'(i)) == WS_END)
                          || (wait_value(lcdn_wsrc(POS_W'(i)), cfg) != '0);
        end
    end

    // Entry point of an accepted command, or the position after the current one.
    always_comb
    begin
        start_pos = pos_reg + POS_W'(1);
        from_pos  = pos_reg;
        if (fire && (item.op != OP_TICK) && (item.op <= OP_CLEAR) && !busy)
        begin
            unique case (item.op)
                OP_INIT:  start_pos = POS_INIT_FIRST;
                OP_CLEAR: start_pos = POS_CLEAR_FIRST;
                default:  start_pos = POS_USER_FIRST;
            endcase
            from_pos = start_pos;
        end
    end

    // First holding position at or after the start point; zero waits fall through.
    always_comb
    begin
        stop_pos = POS_IDLE;
        for (int i = POS_COUNT - 1; i >= 0; i--)
        begin
            if ((i >= int'(start_pos)) && stop_vec[i])
            begin
                stop_pos = POS_W'(i);
            end
        end
    end

    assign prev = lcdn_prev_e0(stop_pos);

    // Decode the word and work out where the sequence settles.
    always_comb
    begin
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        latch_next = latch_reg;
        en_next    = en_reg;
        sel_next   = sel_reg;
        nib_next   = nib_reg;
        rejected   = 1'b0;
        run        = 1'b0;

        if (fire)
        begin
            if (item.op == OP_TICK)
            begin
                if (busy)
                begin
                    if (cnt_reg > WAIT_W'(1))
                    begin
                        cnt_next = cnt_reg - WAIT_W'(1);
                    end
                    else
                    begin
                        run = 1'b1;
                    end
                end
            end
            else if (item.op <= OP_CLEAR)
            begin
                if (busy)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    run = 1'b1;
                    unique case (item.op)
                        OP_INIT:
                        begin
                            sel_next = 1'b0;
                        end
                        OP_CLEAR:
                        begin
                            sel_next = 1'b0;
                        end
                        OP_POS:
                        begin
                            sel_next   = 1'b0;
                            latch_next = addr_byte;
                        end
                        OP_DATA:
                        begin
                            sel_next   = 1'b1;
                            latch_next = item.value;
                        end
                        default:
                        begin
                            sel_next   = 1'b0;
                            latch_next = item.value;
                        end
                    endcase
                end
            end
        end

        // Land on the holding position and update the pins passed on the way.
        if (run)
        begin
            pos_next = stop_pos;
            cnt_next = wait_value(lcdn_wsrc(stop_pos), cfg);
            en_next  = lcdn_is_e0(stop_pos);
            if (prev.valid && (prev.pos >= from_pos))
            begin
                nib_next = lcdn_e0_nibble(prev.pos, latch_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_IDLE;
            cnt_reg   <= '0;
            latch_reg <= '0;
            en_reg    <= 1'b0;
            sel_reg   <= 1'b0;
            nib_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            latch_reg <= latch_next;
            en_reg    <= en_next;
            sel_reg   <= sel_next;
            nib_reg   <= nib_next;
        end
    end

    assign res.lcd_enable = en_next;
    assign res.lcd_select = sel_next;
    assign res.lcd_nibble = nib_next;
    assign res.busy_res   = (pos_next != POS_INIT_END) && (pos_next != POS_USER_END)
                            && (pos_next != POS_CLEAR_END);
    assign res.rejected   = rejected;

endmodule

>>> hw/rtl/char_lcd_nibble_write_sequencer_unit.sv
`timescale 1ns / 1ps

// Character LCD controller for a 4-bit HD44780-style bus. Every command word
// (tick, init, command byte, data byte, cursor position, clear) yields one
// result word with the E, RS and D7..D4 levels, the busy flag and a flag for a
// command dropped because a sequence was still running. Words stream at one
// per clock while the result side takes them: a word waits in the input
// register, and when it moves on, the sequence state and the result register
// are updated. While the result side stalls, the input register holds one
// more word and then the command side stalls. Waits of zero length, including
// a zero strobe time, are skipped within the same word. Configuration writes
// are taken in any cycle and apply from the next wait that loads the register.
module char_lcd_nibble_write_sequencer_unit
    import lcdn_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    lcdn_cmd_if.sink   cmd,
    lcdn_res_if.source res,
    lcdn_cfg_if.sink   cfg
);

    item_t   in_reg;
    logic    in_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;
    cfg_t    cfg_word;
    result_t core_res;

    // The held word moves on when the result register is free or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    lcdn_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_word)
    );

    lcdn_seq_core u_seq_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_reg),
        .cfg   (cfg_word),
        .res   (core_res)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_reg.op     <= cmd.op;
            in_reg.value  <= cmd.value;
            in_reg.column <= cmd.column;
            in_reg.row    <= cmd.row;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= core_res;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.lcd_enable = out_reg.lcd_enable;
    assign res.lcd_select = out_reg.lcd_select;
    assign res.lcd_nibble = out_reg.lcd_nibble;
    assign res.busy_res   = out_reg.busy_res;
    assign res.rejected   = out_reg.rejected;

endmodule

>>> hw/rtl/lcdn_checker.sv
`timescale 1ns / 1ps

module lcdn_checker
    import lcdn_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             res_valid,
    input logic             res_ready,
    input logic             res_enable,
    input logic             res_select,
    input logic [NIB_W-1:0] res_nibble,
    input logic             res_busy,
    input logic             res_rejected,
    input logic             cfg_ready
);

    // A stalled result word keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_enable)
        && $stable(res_select) && $stable(res_nibble) && $stable(res_busy)
        && $stable(res_rejected))
        else $error("stalled result word changed");

    // A dropped command can only happen while a sequence is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_rejected |-> res_busy)
        else $error("command rejected while idle");

    // E is always low once a sequence has finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_busy |-> !res_enable)
        else $error("E left high while idle");

    // The configuration port never stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind char_lcd_nibble_write_sequencer_unit lcdn_checker u_lcdn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_enable   (res.lcd_enable),
    .res_select   (res.lcd_select),
    .res_nibble   (res.lcd_nibble),
    .res_busy     (res.busy_res),
    .res_rejected (res.rejected),
    .cfg_ready    (cfg.ready)
);
